FILE: rtl/tc_pkg.sv
// ----------------------------------------------------------------------------
// tc_pkg
// shared widths, field sizes and sequencer states of the closure unit
// ----------------------------------------------------------------------------
package tc_pkg;

  localparam int ROW_W      = 32;  // bits per adjacency row
  localparam int IDX_W      = 5;   // row index field width
  localparam int CNT_W      = 6;   // vertex counters, hold 0..32
  localparam int VC_W       = 6;   // vertex_count register width
  localparam int TDATA_W    = 40;  // index + row, padded to whole bytes
  localparam int APB_AW     = 3;   // byte address of the single register
  localparam int APB_DW     = 32;

  localparam logic REG_VERTEX_COUNT = 1'b0;  // register index, paddr[2]

  typedef enum logic [2:0] {
    ST_IDLE,    // loading rows
    ST_PIV,     // read pivot row
    ST_PIVW,    // capture pivot row
    ST_SWEEP,   // read rows, write back in the cycle after each read
    ST_DRAIN,   // last write-back of this pivot
    ST_EMIT,    // read next closed row
    ST_EMITW    // move row into output register
  } tc_state_t;

endpackage

FILE: rtl/transitive_closure_unit.sv
// ----------------------------------------------------------------------------
// transitive_closure_unit
// warshall transitive closure over a row-per-transfer adjacency matrix
// ----------------------------------------------------------------------------
//
// channel   dir  handshake                 contents
// s_axis    in   tvalid/tready             tdata: row_index, row_bits; tlast: last_row
// m_axis    out  tvalid/tready             tdata: out_row_index, reach_bits; tlast: last_out
// apb       in   psel/penable/pwrite       vertex_count at byte address 0
//
// every row transfer, tlast or not, writes the row memory
// a tlast transfer starts the closure: for each of n pivots, the pivot row is
// read and captured, each row is read with its write-back registered behind
// it, and the last write-back drains; then each closed row is read and moved
// into the output register, n = effective vertex count
// the input side stays stalled from the tlast transfer until the last closed
// row sits in the output register; a stalled output holds the sequencer
// reset and the end of every emitted matrix clear the row valid bits at once
// ----------------------------------------------------------------------------
module transitive_closure_unit #(
  parameter int MAX_VERTICES = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  // input rows
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [tc_pkg::TDATA_W-1:0]    s_axis_tdata,   // [4:0] row_index, [36:5] row_bits
  input  logic                          s_axis_tlast,   // last_row
  // closed rows
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [tc_pkg::TDATA_W-1:0]    m_axis_tdata,   // [4:0] out_row_index, [36:5] reach_bits
  output logic                          m_axis_tlast,   // last_out
  // configuration
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [tc_pkg::APB_AW-1:0]     paddr,
  input  logic [tc_pkg::APB_DW-1:0]     pwdata,
  output logic [tc_pkg::APB_DW-1:0]     prdata,
  output logic                          pready
);

  // rows beyond the index field or the store are never kept
  localparam int DEPTH  = (MAX_VERTICES < tc_pkg::ROW_W) ? MAX_VERTICES : tc_pkg::ROW_W;
  localparam int ADDR_W = $clog2(DEPTH);

  localparam int ROW_W = tc_pkg::ROW_W;
  localparam int CNT_W = tc_pkg::CNT_W;

  // --------------------------------------------------------------------------
  // configuration register
  // --------------------------------------------------------------------------
  logic [tc_pkg::VC_W-1:0] vertex_count;
  logic                    reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = (paddr[2] == tc_pkg::REG_VERTEX_COUNT);

  always_ff @(posedge clk) begin
    if (rst) begin
      vertex_count <= tc_pkg::VC_W'(32);
    end else if (psel && penable && pwrite && pready && reg_sel) begin
      vertex_count <= pwdata[tc_pkg::VC_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (reg_sel) begin
      prdata = tc_pkg::APB_DW'(vertex_count);
    end
  end

  // effective count: zero acts as one, large values saturate to the store
  logic [CNT_W-1:0] n_eff;
  logic [ROW_W-1:0] mask_eff;

  always_comb begin
    n_eff = CNT_W'(vertex_count);
    if (n_eff == '0) begin
      n_eff = CNT_W'(1);
    end
    if (n_eff > CNT_W'(DEPTH)) begin
      n_eff = CNT_W'(DEPTH);
    end
    if (n_eff >= CNT_W'(ROW_W)) begin
      mask_eff = '1;
    end else begin
      mask_eff = (ROW_W'(1) << n_eff) - ROW_W'(1);
    end
  end

  // --------------------------------------------------------------------------
  // input fields
  // --------------------------------------------------------------------------
  logic [tc_pkg::IDX_W-1:0] row_index;
  logic [ROW_W-1:0]         row_bits;
  logic                     s_xfer;

  assign row_index = s_axis_tdata[tc_pkg::IDX_W-1:0];
  assign row_bits  = s_axis_tdata[tc_pkg::IDX_W +: ROW_W];
  assign s_xfer    = s_axis_tvalid && s_axis_tready;

  // --------------------------------------------------------------------------
  // sequencer registers
  // --------------------------------------------------------------------------
  tc_pkg::tc_state_t state, state_next;

  logic [CNT_W-1:0]  n_cnt;       // count latched at closure start
  logic [ROW_W-1:0]  col_mask;    // columns in use
  logic [CNT_W-1:0]  k;           // pivot
  logic [CNT_W-1:0]  i;           // row being read in the sweep or emit
  logic [ROW_W-1:0]  pivot_row;
  logic              s1_valid;    // write-back stage
  logic [ADDR_W-1:0] s1_addr;

  // --------------------------------------------------------------------------
  // row memory with per-row valid bits, registered read
  // --------------------------------------------------------------------------
  logic [ROW_W-1:0]  mem [DEPTH];
  logic [DEPTH-1:0]  row_vld;
  logic              rd_en;
  logic [ADDR_W-1:0] rd_addr;
  logic [ROW_W-1:0]  rd_q;
  logic              rd_vld;
  logic [ROW_W-1:0]  rd_row;
  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  logic [ROW_W-1:0]  wr_data;
  logic              clear_all;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_vld <= '0;
      rd_vld  <= 1'b0;
    end else begin
      if (rd_en) begin
        rd_vld <= row_vld[rd_addr];
      end
      if (clear_all) begin
        row_vld <= '0;
      end else if (wr_en) begin
        row_vld[wr_addr] <= 1'b1;
      end
    end
  end

  // rows never loaded read as empty, columns at or above n are dropped
  assign rd_row = rd_vld ? (rd_q & col_mask) : '0;

  // --------------------------------------------------------------------------
  // next state and memory control
  // --------------------------------------------------------------------------
  logic out_free;
  logic row_last;
  logic piv_last;

  assign out_free = !m_axis_tvalid || m_axis_tready;
  assign row_last = (i == n_cnt - CNT_W'(1));
  assign piv_last = (k == n_cnt - CNT_W'(1));
  assign s_axis_tready = (state == tc_pkg::ST_IDLE);

  always_comb begin
    state_next = state;
    rd_en      = 1'b0;
    rd_addr    = '0;
    wr_en      = 1'b0;
    wr_addr    = '0;
    wr_data    = '0;
    clear_all  = 1'b0;

    // write-back: row |= pivot when the row reaches the pivot
    if (s1_valid) begin
      wr_en   = 1'b1;
      wr_addr = s1_addr;
      wr_data = rd_row[k[tc_pkg::IDX_W-1:0]] ? (rd_row | pivot_row) : rd_row;
    end

    case (state)
      tc_pkg::ST_IDLE: begin
        if (s_xfer && ({1'b0, row_index} < CNT_W'(DEPTH))) begin
          wr_en   = 1'b1;
          wr_addr = row_index[ADDR_W-1:0];
          wr_data = row_bits;
        end
        if (s_xfer && s_axis_tlast) begin
          state_next = tc_pkg::ST_PIV;
        end
      end
      tc_pkg::ST_PIV: begin
        rd_en      = 1'b1;
        rd_addr    = k[ADDR_W-1:0];
        state_next = tc_pkg::ST_PIVW;
      end
      tc_pkg::ST_PIVW: begin
        state_next = tc_pkg::ST_SWEEP;
      end
      tc_pkg::ST_SWEEP: begin
        rd_en   = 1'b1;
        rd_addr = i[ADDR_W-1:0];
        if (row_last) begin
          state_next = tc_pkg::ST_DRAIN;
        end
      end
      tc_pkg::ST_DRAIN: begin
        // next pivot read waits for this write-back to land
        state_next = piv_last ? tc_pkg::ST_EMIT : tc_pkg::ST_PIV;
      end
      tc_pkg::ST_EMIT: begin
        if (out_free) begin
          rd_en      = 1'b1;
          rd_addr    = i[ADDR_W-1:0];
          state_next = tc_pkg::ST_EMITW;
        end
      end
      tc_pkg::ST_EMITW: begin
        if (row_last) begin
          clear_all  = 1'b1;
          state_next = tc_pkg::ST_IDLE;
        end else begin
          state_next = tc_pkg::ST_EMIT;
        end
      end
      default: begin
        state_next = tc_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tc_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // --------------------------------------------------------------------------
  // counters and pipeline registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      k        <= '0;
      i        <= '0;
      n_cnt    <= CNT_W'(1);
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= (state == tc_pkg::ST_SWEEP);
      case (state)
        tc_pkg::ST_IDLE: begin
          if (s_xfer && s_axis_tlast) begin
            n_cnt <= n_eff;
            k     <= '0;
            i     <= '0;
          end
        end
        tc_pkg::ST_PIVW: begin
          i <= '0;
        end
        tc_pkg::ST_SWEEP: begin
          i <= i + CNT_W'(1);
        end
        tc_pkg::ST_DRAIN: begin
          k <= k + CNT_W'(1);
          i <= '0;
        end
        tc_pkg::ST_EMITW: begin
          if (row_last) begin
            k <= '0;
            i <= '0;
          end else begin
            i <= i + CNT_W'(1);
          end
        end
        default: begin
        end
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (state == tc_pkg::ST_IDLE && s_xfer && s_axis_tlast) begin
      col_mask <= mask_eff;
    end
    if (state == tc_pkg::ST_PIVW) begin
      pivot_row <= rd_row;
    end
    s1_addr <= i[ADDR_W-1:0];
  end

  // --------------------------------------------------------------------------
  // output register
  // --------------------------------------------------------------------------
  logic [tc_pkg::IDX_W-1:0] out_row_index;
  logic [ROW_W-1:0]         reach_bits;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (state == tc_pkg::ST_EMITW) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == tc_pkg::ST_EMITW) begin
      out_row_index <= i[tc_pkg::IDX_W-1:0];
      reach_bits    <= rd_row;
      m_axis_tlast  <= row_last;
    end
  end

  assign m_axis_tdata = {{(tc_pkg::TDATA_W - tc_pkg::IDX_W - ROW_W){1'b0}},
                         reach_bits, out_row_index};

endmodule

FILE: dv/transitive_closure_unit_tb.sv
// ----------------------------------------------------------------------------
// transitive_closure_unit_tb
// self-checking bench for the warshall closure unit
// ----------------------------------------------------------------------------
// rows stream in on s_axis and a tlast row starts the closure. the bench keeps
// its own adjacency store, closes it when the tlast transfer is accepted, and
// compares every closed row on m_axis with the oldest row still owed.
// vertex_count is rewritten over apb between phases, only while the unit idles.
// ----------------------------------------------------------------------------
module transitive_closure_unit_tb;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int          ITEM_TARGET = 470;          // stop queuing rows here
  localparam int          CALM_FROM   = 400;          // no idling past this point
  localparam int          LONG_HOLD   = 400;          // cycles of receiver hold-off
  localparam int          SETTLE      = 8;            // idle cycles before a write
  localparam logic [2:0]  VC_ADDR     = {tc_pkg::REG_VERTEX_COUNT, 2'b00};
  localparam logic [2:0]  SPARE_ADDR  = 3'b100;       // no register lives here

  typedef struct {
    logic [tc_pkg::IDX_W-1:0] idx;
    logic [tc_pkg::ROW_W-1:0] bits;
    logic                     last;
  } row_xfer_t;

  // dut ports, bench-driven inputs known from time zero
  logic                        clk = 1'b0;
  logic                        rst = 1'b1;
  logic                        s_axis_tvalid = 1'b0;
  logic                        s_axis_tready;
  logic [tc_pkg::TDATA_W-1:0]  s_axis_tdata = '0;
  logic                        s_axis_tlast = 1'b0;
  logic                        m_axis_tvalid;
  logic                        m_axis_tready = 1'b0;
  logic [tc_pkg::TDATA_W-1:0]  m_axis_tdata;
  logic                        m_axis_tlast;
  logic                        psel = 1'b0;
  logic                        penable = 1'b0;
  logic                        pwrite = 1'b0;
  logic [tc_pkg::APB_AW-1:0]   paddr = '0;
  logic [tc_pkg::APB_DW-1:0]   pwdata = '0;
  logic [tc_pkg::APB_DW-1:0]   prdata;
  logic                        pready;

  // bench state
  row_xfer_t                   rows_to_send[$];     // rows waiting for the driver
  row_xfer_t                   closed_rows_due[$];  // closed rows the unit still owes
  row_xfer_t                   row_on_bus;          // row currently offered
  row_xfer_t                   got;
  row_xfer_t                   want;
  logic [tc_pkg::ROW_W-1:0]    graph_rows[32];      // bench copy of the adjacency store
  logic [tc_pkg::VC_W-1:0]     vertex_limit = 6'd32;
  int                          mismatches = 0;
  int                          sent_count = 0;
  int                          send_gap = 0;
  int                          stall_left = 0;
  int                          hold_left = 0;
  bit                          hold_off_ask = 1'b0;
  bit                          calm = 1'b0;

  transitive_closure_unit #(.MAX_VERTICES(32)) DUT (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),   // [4:0] row_index, [36:5] row_bits
    .s_axis_tlast  (s_axis_tlast),   // last_row
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),   // [4:0] out_row_index, [36:5] reach_bits
    .m_axis_tlast  (m_axis_tlast),   // last_out
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // register value to vertices in use: zero means one, above 32 saturates
  function automatic int clamp_count(input logic [tc_pkg::VC_W-1:0] v);
    int n;
    n = v;
    if (n < 1) n = 1;
    if (n > 32) n = 32;
    return n;
  endfunction

  // store an accepted row; a tlast row closes the graph and owes n rows
  task automatic absorb_row(input row_xfer_t r);
    int                       n;
    logic [tc_pkg::ROW_W-1:0] mask;
    row_xfer_t                c;
    graph_rows[r.idx] = r.bits;
    if (r.last) begin
      n = clamp_count(vertex_limit);
      mask = (n >= 32) ? '1 : ((32'h1 << n) - 32'h1);
      for (int i = 0; i < n; i++) graph_rows[i] &= mask;
      // warshall: row i picks up row k whenever it reaches pivot k
      for (int k = 0; k < n; k++)
        for (int i = 0; i < n; i++)
          if (graph_rows[i][k]) graph_rows[i] |= graph_rows[k];
      for (int i = 0; i < n; i++) begin
        c.idx  = i[tc_pkg::IDX_W-1:0];
        c.bits = graph_rows[i];
        c.last = (i == n - 1);
        closed_rows_due.push_back(c);
      end
      for (int i = 0; i < 32; i++) graph_rows[i] = '0;
    end
  endtask

  // ---------------------------------------------------------------- driver
  // a held row stays on the bus; a fresh row goes out unless an idle burst
  // is drawn, so gaps land before loads, tlast rows and stalled closures
  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
      send_gap = 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) absorb_row(row_on_bus);
      if (s_axis_tvalid && !s_axis_tready) begin
        // unit is busy closing, keep offering
      end else if (send_gap > 0) begin
        send_gap--;
        s_axis_tvalid <= 1'b0;
      end else if (rows_to_send.size() > 0) begin
        if (!calm && $urandom_range(0, 5) == 0) begin
          send_gap = $urandom_range(1, 12) - 1;
          s_axis_tvalid <= 1'b0;
        end else begin
          row_on_bus = rows_to_send.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= {3'b000, row_on_bus.bits, row_on_bus.idx};
          s_axis_tlast  <= row_on_bus.last;
        end
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // -------------------------------------------------------------- receiver
  // random stall bursts, plus one long hold-off that backs the unit up
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
      stall_left = 0;
      hold_left = 0;
    end else begin
      if (hold_off_ask) begin
        hold_left = LONG_HOLD;
        hold_off_ask = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        m_axis_tready <= 1'b0;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 12) - 1;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // --------------------------------------------------------------- monitor
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got.idx  = m_axis_tdata[tc_pkg::IDX_W-1:0];
      got.bits = m_axis_tdata[tc_pkg::IDX_W +: tc_pkg::ROW_W];
      got.last = m_axis_tlast;
      if (closed_rows_due.size() == 0) begin
        $display("%0t: unexpected closed row, expected none, actual idx %0d bits %h last %b",
                 $time, got.idx, got.bits, got.last);
        mismatches++;
      end else begin
        want = closed_rows_due.pop_front();
        if (got.idx !== want.idx) begin
          $display("%0t: out_row_index expected %0d actual %0d", $time, want.idx, got.idx);
          mismatches++;
        end
        if (got.bits !== want.bits) begin
          $display("%0t: reach_bits of row %0d expected %h actual %h",
                   $time, want.idx, want.bits, got.bits);
          mismatches++;
        end
        if (got.last !== want.last) begin
          $display("%0t: last_out of row %0d expected %b actual %b",
                   $time, want.idx, want.last, got.last);
          mismatches++;
        end
      end
    end
  end

  // ------------------------------------------------------------- stimulus
  task automatic push_row(input int idx, input logic [tc_pkg::ROW_W-1:0] bits, input bit last);
    row_xfer_t r;
    r.idx  = idx[tc_pkg::IDX_W-1:0];
    r.bits = bits;
    r.last = last;
    rows_to_send.push_back(r);
    sent_count++;
  endtask

  // sender pause: every queued row taken, every closed row back, unit settled
  task automatic wait_quiet();
    @(negedge clk);
    while (rows_to_send.size() > 0 || s_axis_tvalid || closed_rows_due.size() > 0)
      @(negedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // apb write: setup, access, register written on the access edge
  task automatic write_reg(input logic [2:0] addr, input logic [31:0] data);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (addr == VC_ADDR) vertex_limit = data[tc_pkg::VC_W-1:0];
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // row content mix: dense noise, sparse edges, chains for long paths, empty
  function automatic logic [tc_pkg::ROW_W-1:0] row_content(input int n, input int v);
    logic [tc_pkg::ROW_W-1:0] b;
    case ($urandom_range(0, 4))
      0: b = $urandom();
      1: b = 32'h1 << $urandom_range(0, n - 1);
      2: b = (32'h1 << $urandom_range(0, n - 1)) | (32'h1 << $urandom_range(0, n - 1));
      3: b = (v + 1 < n) ? (32'h1 << (v + 1)) : 32'h1;
      default: b = '0;
    endcase
    return b;
  endfunction

  // well-formed graph: rows 0..n-1 in shuffled order, a few skipped or stray
  task automatic queue_graph(input int n);
    int order[$];
    int j;
    int tmp;
    order = {};
    for (int i = 0; i < n; i++) order.push_back(i);
    for (int i = n - 1; i > 0; i--) begin
      j = $urandom_range(0, i);
      tmp = order[i];
      order[i] = order[j];
      order[j] = tmp;
    end
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 7) != 0) push_row(order[i], row_content(n, order[i]), 1'b0);
      if ($urandom_range(0, 15) == 0) push_row($urandom_range(0, 31), $urandom(), 1'b0);
    end
    tmp = $urandom_range(0, n - 1);
    push_row(tmp, row_content(n, tmp), 1'b1);
  endtask

  // broken sequence: random rows anywhere, tlast not always sent
  task automatic queue_noise();
    repeat ($urandom_range(1, 5)) push_row($urandom_range(0, 31), $urandom(), 1'b0);
    if ($urandom_range(0, 3) != 0) push_row($urandom_range(0, 31), $urandom(), 1'b1);
  endtask

  initial begin
    logic [tc_pkg::VC_W-1:0] vc;
    int                      n;
    int                      graphs;
    bit                      first;
    for (int i = 0; i < 32; i++) graph_rows[i] = '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // reset count of 32: loop through rows 0, 1 and 2, duplicate load, top row self loop,
    // untouched rows stay empty
    @(negedge clk);
    push_row(0, 32'h0000_0002, 1'b0);
    push_row(1, 32'h0000_0004, 1'b0);
    push_row(2, 32'h0000_0001, 1'b0);
    push_row(5, 32'hFFFF_FFFF, 1'b0);
    push_row(5, 32'h0000_0020, 1'b0);
    push_row(31, 32'h8000_0000, 1'b1);

    // count zero acts as one vertex
    wait_quiet();
    write_reg(VC_ADDR, 32'hFFFF_FFC0);
    @(negedge clk);
    push_row(0, 32'hFFFF_FFFF, 1'b1);
    push_row(7, 32'h0000_00FF, 1'b0);
    push_row(0, 32'h0000_0003, 1'b1);

    // one vertex, self loop only
    wait_quiet();
    write_reg(VC_ADDR, 32'd1);
    @(negedge clk);
    push_row(0, 32'h0000_0001, 1'b1);

    // oversized count saturates to 32
    wait_quiet();
    write_reg(VC_ADDR, 32'd63);
    @(negedge clk);
    push_row(31, 32'hFFFF_FFFF, 1'b1);

    // four vertices: masked columns, row past the count, spare address ignored
    wait_quiet();
    write_reg(VC_ADDR, 32'd4);
    write_reg(SPARE_ADDR, 32'd9);
    @(negedge clk);
    push_row(3, 32'hFFFF_FFF1, 1'b0);
    push_row(10, 32'h0000_FFFF, 1'b0);
    push_row(0, 32'h0000_0002, 1'b0);
    push_row(1, 32'h0000_0008, 1'b1);

    // random phases, mostly small graphs
    first = 1'b1;
    while (sent_count < ITEM_TARGET) begin
      wait_quiet();
      case ($urandom_range(0, 11))
        0:       vc = 6'd0;
        1:       vc = 6'($urandom_range(33, 63));
        2:       vc = 6'd32;
        10, 11:  vc = 6'($urandom_range(13, 31));
        default: vc = 6'($urandom_range(1, 12));
      endcase
      // upper register bits are don't-care, fill them with noise
      write_reg(VC_ADDR, {26'($urandom()), vc});
      if ($urandom_range(0, 4) == 0) write_reg(SPARE_ADDR, $urandom());
      n = clamp_count(vc);
      @(negedge clk);
      if (sent_count >= CALM_FROM) calm = 1'b1;
      graphs = first ? 3 : $urandom_range(1, 3);
      if (first) hold_off_ask = 1'b1;  // sender keeps offering behind the hold
      repeat (graphs) begin
        // the held phase always closes each graph so the input backs up
        if (!first && $urandom_range(0, 4) == 0) queue_noise();
        else queue_graph(n);
      end
      first = 1'b0;
    end

    wait_quiet();
    repeat (50) @(posedge clk);
    if (mismatches == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

  // watchdog
  initial begin
    #20_000_000;
    $display("status: fail");
    $finish;
  end

endmodule

FILE: filelist.f
rtl/tc_pkg.sv
rtl/transitive_closure_unit.sv
dv/transitive_closure_unit_tb.sv
